/* rtl/assert_macros.svh */
// Assertion macros shared by the converter RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hsvrgb_pkg.sv */
// Package for the HSV/HSL to RGB converter: request/result types and scaling constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsvrgb_pkg;

    localparam int unsigned DENOM       = 1200000;
    localparam int unsigned SCALE_MUL   = 255;
    localparam int unsigned SCALE_SHIFT = 22;
    localparam int unsigned SCALE_RECIP = (SCALE_MUL * (1 << SCALE_SHIFT)) / DENOM;

    localparam int unsigned SUM_W  = 22;
    localparam int unsigned PART_W = 21;
    localparam int unsigned EST_W  = 10;
    localparam int unsigned P255_W = 30;

    typedef enum logic {
        MODE_HSV = 1'b0,
        MODE_HSL = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic              mode;
        logic [9:0]        hue;
        logic signed [7:0] saturation;
        logic signed [7:0] level;
        logic [7:0]        alpha_in;
    } t_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } t_res;

endpackage
`default_nettype wire

/* rtl/hsv_hsl_to_rgb_converter.sv */
// Top level of the HSV/HSL to RGB converter: five front stages plus three channel scalers.
// Depends on hsvrgb_pkg, hsvrgb_scale and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Usage:
//   Drive i_req and raise i_start; a request is taken at each rising edge where
//   i_start is high and o_busy is low. o_busy is high only while reset is held,
//   so one request per clock is taken at full rate.
//   Each request yields exactly one result on o_res, marked by o_strobe for one
//   cycle. o_strobe rises after these registered steps: hue reduction and
//   clamping, sector and lightness weight, the 7x7 base product, the chroma and
//   offset multiplies, channel sums, then the register stages of each channel scaler
//   (reciprocal multiply, then a back-multiply with a one-step correction).
//   Throughput is one result per cycle; results emerge in request order.
//   Synchronous active-low reset clears all valid bits; requests in flight are
//   dropped and no result appears for them.
//   The receiver cannot stall: a result must be taken in its strobe cycle.
//   Channels are floor(255*(P+M)/1200000) with exact integer arithmetic;
//   alpha_in is copied to alpha_out.
module hsv_hsl_to_rgb_converter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire hsvrgb_pkg::t_req  i_req,
    output logic                   o_busy,
    output logic                   o_strobe,
    output hsvrgb_pkg::t_res       o_res
);

    localparam int unsigned NSTAGE   = 7;
    localparam int unsigned HUE_FULL = 360;
    localparam int unsigned PART_W   = hsvrgb_pkg::PART_W;
    localparam int unsigned SUM_W    = hsvrgb_pkg::SUM_W;

    function automatic logic [6:0] clamp_pct(input logic signed [7:0] v);
        logic [6:0] res;
        if (v < 8'sd0) begin
            res = 7'd0;
        end else if (v > 8'sd100) begin
            res = 7'd100;
        end else begin
            res = v[6:0];
        end
        return res;
    endfunction

    logic w_accept;
    logic [NSTAGE-1:0] r_vld;

    // stage 1
    logic [8:0] n_s1_h;
    logic [6:0] n_s1_sat, n_s1_lvl;
    logic [8:0] r_s1_h;
    logic [6:0] r_s1_sat, r_s1_lvl;
    logic       r_s1_mode;
    logic [7:0] r_s1_alpha;

    // stage 2
    hsvrgb_pkg::t_sector n_s2_sect, r_s2_sect;
    logic [6:0] n_s2_hm, n_s2_base;
    logic [6:0] r_s2_hm, r_s2_base, r_s2_sat, r_s2_lvl;
    logic       r_s2_mode;
    logic [7:0] r_s2_alpha;

    // stage 3
    logic [5:0]  n_s3_k;
    logic [13:0] n_s3_p;
    logic [5:0]  r_s3_k;
    logic [13:0] r_s3_p;
    logic [6:0]  r_s3_lvl;
    logic        r_s3_mode;
    hsvrgb_pkg::t_sector r_s3_sect;
    logic [7:0]  r_s3_alpha;

    // stage 4
    logic [PART_W-1:0] n_s4_c, n_s4_x, n_s4_m, w_s4_sub;
    logic [PART_W-1:0] r_s4_c, r_s4_x, r_s4_m;
    hsvrgb_pkg::t_sector r_s4_sect;
    logic [7:0]  r_s4_alpha;

    // stage 5
    logic [SUM_W-1:0] w_s5_cm, w_s5_xm, w_s5_m;
    logic [SUM_W-1:0] n_s5_r, n_s5_g, n_s5_b;
    logic [SUM_W-1:0] r_s5_r, r_s5_g, r_s5_b;
    logic [7:0]  r_s5_alpha;

    // scaler stages
    logic [7:0]  r_s6_alpha, r_s7_alpha;
    logic [7:0]  w_red, w_green, w_blue;

    assign o_busy   = !i_rst_n;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTAGE-2:0], w_accept};
        end
    end

    // reduce hue modulo 360, clamp percentages
    always_comb begin
        if (i_req.hue >= 10'(2 * HUE_FULL)) begin
            n_s1_h = 9'(i_req.hue - 10'(2 * HUE_FULL));
        end else if (i_req.hue >= 10'(HUE_FULL)) begin
            n_s1_h = 9'(i_req.hue - 10'(HUE_FULL));
        end else begin
            n_s1_h = i_req.hue[8:0];
        end
        n_s1_sat = clamp_pct(i_req.saturation);
        n_s1_lvl = clamp_pct(i_req.level);
    end

    // sector, hue within the 120-degree pair, lightness weight
    always_comb begin
        priority if (r_s1_h >= 9'd300) begin
            n_s2_sect = hsvrgb_pkg::SECT_MR;
        end else if (r_s1_h >= 9'd240) begin
            n_s2_sect = hsvrgb_pkg::SECT_BM;
        end else if (r_s1_h >= 9'd180) begin
            n_s2_sect = hsvrgb_pkg::SECT_CB;
        end else if (r_s1_h >= 9'd120) begin
            n_s2_sect = hsvrgb_pkg::SECT_GC;
        end else if (r_s1_h >= 9'd60) begin
            n_s2_sect = hsvrgb_pkg::SECT_YG;
        end else begin
            n_s2_sect = hsvrgb_pkg::SECT_RY;
        end
        priority if (r_s1_h >= 9'd240) begin
            n_s2_hm = 7'(r_s1_h - 9'd240);
        end else if (r_s1_h >= 9'd120) begin
            n_s2_hm = 7'(r_s1_h - 9'd120);
        end else begin
            n_s2_hm = r_s1_h[6:0];
        end
        if (r_s1_mode == hsvrgb_pkg::MODE_HSL) begin
            n_s2_base = (r_s1_lvl >= 7'd50) ? 7'(8'd200 - {r_s1_lvl, 1'b0})
                                            : 7'({r_s1_lvl, 1'b0});
        end else begin
            n_s2_base = r_s1_lvl;
        end
    end

    // ramp weight k and base product
    always_comb begin
        n_s3_k = (r_s2_hm >= 7'd60) ? 6'(7'd120 - r_s2_hm) : r_s2_hm[5:0];
        n_s3_p = 14'(r_s2_base) * 14'(r_s2_sat);
    end

    // chroma, ramp and offset numerators over 1200000
    always_comb begin
        n_s4_c   = PART_W'(r_s3_p) * PART_W'(120);
        n_s4_x   = {20'(20'(r_s3_p) * 20'(r_s3_k)), 1'b0};
        w_s4_sub = (r_s3_mode == hsvrgb_pkg::MODE_HSL) ? PART_W'(r_s3_p) * PART_W'(60)
                                                       : n_s4_c;
        n_s4_m   = PART_W'(r_s3_lvl) * PART_W'(12000) - w_s4_sub;
    end

    // route by sector
    always_comb begin
        w_s5_m  = SUM_W'(r_s4_m);
        w_s5_cm = SUM_W'(r_s4_c) + w_s5_m;
        w_s5_xm = SUM_W'(r_s4_x) + w_s5_m;
        unique case (r_s4_sect)
            hsvrgb_pkg::SECT_RY: begin
                n_s5_r = w_s5_cm; n_s5_g = w_s5_xm; n_s5_b = w_s5_m;
            end
            hsvrgb_pkg::SECT_YG: begin
                n_s5_r = w_s5_xm; n_s5_g = w_s5_cm; n_s5_b = w_s5_m;
            end
            hsvrgb_pkg::SECT_GC: begin
                n_s5_r = w_s5_m;  n_s5_g = w_s5_cm; n_s5_b = w_s5_xm;
            end
            hsvrgb_pkg::SECT_CB: begin
                n_s5_r = w_s5_m;  n_s5_g = w_s5_xm; n_s5_b = w_s5_cm;
            end
            hsvrgb_pkg::SECT_BM: begin
                n_s5_r = w_s5_xm; n_s5_g = w_s5_m;  n_s5_b = w_s5_cm;
            end
            hsvrgb_pkg::SECT_MR: begin
                n_s5_r = w_s5_cm; n_s5_g = w_s5_m;  n_s5_b = w_s5_xm;
            end
            default: begin
                n_s5_r = '0; n_s5_g = '0; n_s5_b = '0;
            end
        endcase
    end

    // advance payload every cycle
    always_ff @(posedge i_clk) begin
        r_s1_h     <= n_s1_h;
        r_s1_sat   <= n_s1_sat;
        r_s1_lvl   <= n_s1_lvl;
        r_s1_mode  <= i_req.mode;
        r_s1_alpha <= i_req.alpha_in;

        r_s2_sect  <= n_s2_sect;
        r_s2_hm    <= n_s2_hm;
        r_s2_base  <= n_s2_base;
        r_s2_sat   <= r_s1_sat;
        r_s2_lvl   <= r_s1_lvl;
        r_s2_mode  <= r_s1_mode;
        r_s2_alpha <= r_s1_alpha;

        r_s3_k     <= n_s3_k;
        r_s3_p     <= n_s3_p;
        r_s3_lvl   <= r_s2_lvl;
        r_s3_mode  <= r_s2_mode;
        r_s3_sect  <= r_s2_sect;
        r_s3_alpha <= r_s2_alpha;

        r_s4_c     <= n_s4_c;
        r_s4_x     <= n_s4_x;
        r_s4_m     <= n_s4_m;
        r_s4_sect  <= r_s3_sect;
        r_s4_alpha <= r_s3_alpha;

        r_s5_r     <= n_s5_r;
        r_s5_g     <= n_s5_g;
        r_s5_b     <= n_s5_b;
        r_s5_alpha <= r_s4_alpha;

        r_s6_alpha <= r_s5_alpha;
        r_s7_alpha <= r_s6_alpha;
    end

    hsvrgb_scale u_scale_r (
        .i_clk  (i_clk),
        .i_sum  (r_s5_r),
        .o_chan (w_red)
    );

    hsvrgb_scale u_scale_g (
        .i_clk  (i_clk),
        .i_sum  (r_s5_g),
        .o_chan (w_green)
    );

    hsvrgb_scale u_scale_b (
        .i_clk  (i_clk),
        .i_sum  (r_s5_b),
        .o_chan (w_blue)
    );

    assign o_strobe        = r_vld[NSTAGE-1];
    assign o_res.red       = w_red;
    assign o_res.green     = w_green;
    assign o_res.blue      = w_blue;
    assign o_res.alpha_out = r_s7_alpha;

    `ASSERT_IMPLIES(a_req_gives_result, i_clk, i_rst_n, w_accept, ##NSTAGE o_strobe)
    `ASSERT_IMPLIES(a_result_had_req, i_clk, i_rst_n, o_strobe, $past(w_accept, NSTAGE))
    `ASSERT_IMPLIES(a_chroma_covers_ramp, i_clk, i_rst_n, r_vld[3], r_s4_x <= r_s4_c)
    `ASSERT_IMPLIES(a_sum_in_range, i_clk, i_rst_n, r_vld[3],
        SUM_W'(r_s4_c) + SUM_W'(r_s4_m) <= SUM_W'(hsvrgb_pkg::DENOM))

endmodule
`default_nettype wire

/* rtl/hsvrgb_scale.sv */
// Channel scaler: floor(sum * 255 / 1200000) saturated to 8 bits, two register stages.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsvrgb_scale (
    input  wire logic                           i_clk,
    input  wire logic [hsvrgb_pkg::SUM_W-1:0]   i_sum,
    output logic      [7:0]                     o_chan
);

    localparam int unsigned PROD_W = hsvrgb_pkg::SUM_W + hsvrgb_pkg::EST_W;
    localparam int unsigned BACK_W = hsvrgb_pkg::P255_W + 1;

    logic [PROD_W-1:0]               w_recip_prod;
    logic [hsvrgb_pkg::EST_W-1:0]    n_est;
    logic [hsvrgb_pkg::P255_W-1:0]   n_p255;
    logic [hsvrgb_pkg::EST_W-1:0]    r_est;
    logic [hsvrgb_pkg::P255_W-1:0]   r_p255;
    logic [BACK_W-1:0]               w_back;
    logic [BACK_W-1:0]               w_rem;
    logic [hsvrgb_pkg::EST_W-1:0]    w_q;
    logic [7:0]                      n_chan;
    logic [7:0]                      r_chan;

    // estimate quotient by reciprocal; it is exact or one low
    always_comb begin
        w_recip_prod = PROD_W'(i_sum) * PROD_W'(hsvrgb_pkg::SCALE_RECIP);
        n_est        = hsvrgb_pkg::EST_W'(w_recip_prod >> hsvrgb_pkg::SCALE_SHIFT);
        n_p255       = hsvrgb_pkg::P255_W'(i_sum) * hsvrgb_pkg::P255_W'(hsvrgb_pkg::SCALE_MUL);
    end

    // correct by one step and saturate
    always_comb begin
        w_back = BACK_W'(r_est) * BACK_W'(hsvrgb_pkg::DENOM);
        w_rem  = BACK_W'(r_p255) - w_back;
        w_q    = (w_rem >= BACK_W'(hsvrgb_pkg::DENOM)) ? r_est + 1'b1 : r_est;
        n_chan = (w_q > hsvrgb_pkg::EST_W'(255)) ? 8'hFF : w_q[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_est  <= n_est;
        r_p255 <= n_p255;
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule
`default_nettype wire
